// ----- src/blc_pkg.sv -----
// Shared types and constants for the backlight level controller.
// Used by blc_update and backlight_level_controller_core; no dependencies.
`default_nettype none

package blc_pkg;

    // Level registers are wide enough for any supported maximum level (up to 255).
    localparam int LEVEL_W = 8;
    localparam int IDLE_W  = 27;
    localparam int LIGHT_W = 16;
    localparam int DUTY_W  = 7;

    // Ambient readings above this are treated as full scale.
    localparam int LIGHT_FULL = 100;
    // Fractional bits of the fixed-point scale in the target mapping.
    localparam int SCALE_SHIFT = 14;

    typedef enum logic [2:0] {
        CMD_RESUME   = 3'd0,
        CMD_DIM      = 3'd1,
        CMD_STEP     = 3'd2,
        CMD_SET_AUTO = 3'd3,
        CMD_ACTIVITY = 3'd4,
        CMD_TICK     = 3'd5,
        CMD_LIGHT    = 3'd6
    } cmd_t;

    typedef struct packed {
        cmd_t                      command;
        logic [7:0]                level_request;
        logic signed [7:0]         level_delta;
        logic                      auto_enable;
        logic [LIGHT_W-1:0]        light_reading;
    } blc_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               auto_flag;
        logic [LEVEL_W-1:0] stored_level;
        logic               stored_auto;
        logic               asleep;
        logic [IDLE_W-1:0]  idle_count;
        logic [LEVEL_W-1:0] drive;
    } blc_state_t;

endpackage

`default_nettype wire

// ----- src/backlight_level_controller_core.sv -----
// Top level of the backlight level controller: input register, state, result register.
// Depends on blc_pkg and blc_update.
`default_nettype none

// Each input item is one backlight event (resume, dim, step, set auto, activity,
// millisecond tick or ambient light sample) and yields exactly one status item with
// the applied duty, the live level, the auto flag and the sleep flag. An item is
// captured in the input register. When the output register is free or being read, it
// is applied to the state registers, and its status is loaded into the output register
// at that same edge. A new item is taken every cycle while the output side keeps up.
// The combinational state update through blc_update sets that rate. The idle limit is
// written through cfg_wr_en/cfg_wr_data; zero disables idle sleep.
module backlight_level_controller_core #(
    parameter int MAX_LEVEL = 100
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [26:0] cfg_wr_data,     // idle_limit_ms

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // level_request[7:0], level_delta[15:8], auto_enable[16], light_reading[32:17], zero fill
    input  logic [39:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,    // command[2:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // duty_percent[6:0], current_level[13:7], auto_active[14], sleeping[15]
    output logic [15:0] m_axis_tdata
);
    import blc_pkg::*;

    localparam int RESET_LEVEL = (60 < MAX_LEVEL) ? 60 : MAX_LEVEL;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = IDLE_W'(30000);

    logic [IDLE_W-1:0] idle_limit_reg;
    logic              in_valid_reg;
    blc_item_t         in_item_reg;
    blc_state_t        state_reg;
    blc_state_t        state_next;
    logic              out_valid_reg;
    logic [15:0]       out_data_reg;
    logic              advance;
    blc_item_t         s_item;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign s_item.command       = cmd_t'(s_axis_tuser);
    assign s_item.level_request = s_axis_tdata[7:0];
    assign s_item.level_delta   = $signed(s_axis_tdata[15:8]);
    assign s_item.auto_enable   = s_axis_tdata[16];
    assign s_item.light_reading = s_axis_tdata[32:17];

    blc_update #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_update (
        .item       (in_item_reg),
        .cur        (state_reg),
        .idle_limit (idle_limit_reg),
        .nxt        (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_limit_reg         <= IDLE_LIMIT_RESET;
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.level        <= LEVEL_W'(RESET_LEVEL);
            state_reg.auto_flag    <= 1'b0;
            state_reg.stored_level <= LEVEL_W'(RESET_LEVEL);
            state_reg.stored_auto  <= 1'b0;
            state_reg.asleep       <= 1'b0;
            state_reg.idle_count   <= '0;
            state_reg.drive        <= LEVEL_W'(RESET_LEVEL);
        end else begin
            if (cfg_wr_en) begin
                idle_limit_reg <= cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_data_reg <= {state_next.asleep, state_next.auto_flag,
                             state_next.level[DUTY_W-1:0], state_next.drive[DUTY_W-1:0]};
        end
    end

    // The live level always stays within 1..MAX_LEVEL.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.level >= LEVEL_W'(1) && state_reg.level <= LEVEL_W'(MAX_LEVEL))
        else $error("level outside 1..MAX_LEVEL");

    // While awake, the applied drive follows the live level.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.asleep |-> state_reg.drive == state_reg.level)
        else $error("drive differs from level while awake");

    // An item leaving the input register always lands in the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

    // An item held in the input register is not dropped while the output stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending item lost");

endmodule

`default_nettype wire

// ----- src/blc_update.sv -----
// Next-state logic of the backlight controller for one event item.
// Depends on blc_pkg for the item and state types and the command codes.
`default_nettype none

module blc_update #(
    parameter int MAX_LEVEL = 100
) (
    input  blc_pkg::blc_item_t            item,
    input  blc_pkg::blc_state_t           cur,
    input  logic [blc_pkg::IDLE_W-1:0]    idle_limit,
    output blc_pkg::blc_state_t           nxt
);
    import blc_pkg::*;

    // target - 1 = floor(v * (MAX_LEVEL-1) / 100) computed as (v * SCALE_K) >> SCALE_SHIFT.
    // The rounding error of SCALE_K stays below 1/100 for v up to 100, so the floor is exact.
    localparam int SCALE_K = (((MAX_LEVEL - 1) << SCALE_SHIFT) + LIGHT_FULL - 1) / LIGHT_FULL;
    localparam int PROD_W  = 24;
    localparam int SUM_W   = LEVEL_W + 2;

    logic signed [SUM_W-1:0]   step_sum;
    logic [LEVEL_W-1:0]        step_level;
    logic [LEVEL_W-1:0]        dim_level;
    logic [6:0]                light_sat;
    logic [PROD_W-1:0]         scale_prod;
    logic [LEVEL_W-1:0]        target;
    logic [IDLE_W-1:0]         idle_inc;

    always_comb begin
        step_sum = $signed({2'b00, cur.level}) + SUM_W'(item.level_delta);
        if (step_sum < SUM_W'(1)) begin
            step_level = LEVEL_W'(1);
        end else if (step_sum > SUM_W'(MAX_LEVEL)) begin
            step_level = LEVEL_W'(MAX_LEVEL);
        end else begin
            step_level = step_sum[LEVEL_W-1:0];
        end

        if (item.level_request < 8'd1) begin
            dim_level = LEVEL_W'(1);
        end else if ({1'b0, item.level_request} > 9'(MAX_LEVEL)) begin
            dim_level = LEVEL_W'(MAX_LEVEL);
        end else begin
            dim_level = LEVEL_W'(item.level_request);
        end

        light_sat  = (item.light_reading > LIGHT_W'(LIGHT_FULL)) ?
                     7'(LIGHT_FULL) : item.light_reading[6:0];
        scale_prod = PROD_W'(light_sat) * PROD_W'(SCALE_K);
        target     = LEVEL_W'(scale_prod >> SCALE_SHIFT) + LEVEL_W'(1);

        idle_inc = (cur.idle_count == '1) ? cur.idle_count : cur.idle_count + IDLE_W'(1);
    end

    always_comb begin
        nxt = cur;
        case (item.command)
            CMD_RESUME: begin
                nxt.auto_flag = cur.stored_auto;
                nxt.level     = cur.stored_level;
                nxt.drive     = cur.stored_level;
            end
            CMD_DIM: begin
                nxt.auto_flag = 1'b0;
                nxt.level     = dim_level;
                nxt.drive     = dim_level;
            end
            CMD_STEP: begin
                nxt.auto_flag    = 1'b0;
                nxt.stored_auto  = 1'b0;
                nxt.level        = step_level;
                nxt.drive        = step_level;
                nxt.stored_level = step_level;
            end
            CMD_SET_AUTO: begin
                nxt.auto_flag   = item.auto_enable;
                nxt.stored_auto = item.auto_enable;
                if (!item.auto_enable) begin
                    nxt.level = cur.stored_level;
                    nxt.drive = cur.stored_level;
                end
            end
            CMD_ACTIVITY: begin
                nxt.idle_count = '0;
                if (cur.asleep) begin
                    nxt.asleep = 1'b0;
                    nxt.drive  = cur.level;
                end
            end
            CMD_TICK: begin
                nxt.idle_count = idle_inc;
                if (idle_limit != '0 && !cur.asleep && idle_inc > idle_limit) begin
                    nxt.asleep = 1'b1;
                    nxt.drive  = '0;
                end
            end
            CMD_LIGHT: begin
                // Glide one step toward the mapped target; target never exceeds MAX_LEVEL.
                if (cur.auto_flag && !cur.asleep) begin
                    if (target > cur.level) begin
                        nxt.level = cur.level + LEVEL_W'(1);
                        nxt.drive = cur.level + LEVEL_W'(1);
                    end else if (target < cur.level) begin
                        nxt.level = cur.level - LEVEL_W'(1);
                        nxt.drive = cur.level - LEVEL_W'(1);
                    end
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- tb/backlight_level_controller_core_tb.sv -----
// Self-checking testbench for backlight_level_controller_core: directed and random events
// on the input stream, each status item on the result stream checked against a predictor.
// Depends on blc_pkg and the RTL of the core.
`default_nettype none

module backlight_level_controller_core_tb;
    import blc_pkg::*;

    localparam int MAX_LEVEL     = 100;
    localparam int RESET_LEVEL   = (60 < MAX_LEVEL) ? 60 : MAX_LEVEL;
    localparam int IDLE_SAT      = (1 << 27) - 1;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int PRESSURE_AT   = 300;
    localparam int PRESSURE_HOLD = 150;
    localparam int RANDOM_ITEMS  = 950;
    localparam int NUM_PHASES    = 7;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  req;
        logic [7:0]  delta;
        logic        en;
        logic [15:0] light;
    } bl_event_t;

    typedef struct {
        logic [6:0] duty;
        logic [6:0] level;
        logic       auto_on;
        logic       sleeping;
    } bl_status_t;

    class backlight_predictor;
        int idle_limit;
        int level;
        int auto_flag;
        int stored_level;
        int stored_auto;
        int asleep;
        int idle_count;
        int drive;
        int errors;
        bl_status_t expected_status[$];

        function new();
            idle_limit   = 30000;
            level        = RESET_LEVEL;
            auto_flag    = 0;
            stored_level = RESET_LEVEL;
            stored_auto  = 0;
            asleep       = 0;
            idle_count   = 0;
            drive        = RESET_LEVEL;
            errors       = 0;
        endfunction

        function void set_idle_limit(int v);
            idle_limit = v;
        endfunction

        function void apply_level(int v);
            if (v < 1) level = 1;
            else if (v > MAX_LEVEL) level = MAX_LEVEL;
            else level = v;
            drive = level;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void note_event(bl_event_t ev);
            int d;
            int v;
            int target;
            bl_status_t st;
            d = int'($signed(ev.delta));
            case (ev.cmd)
                CMD_RESUME: begin
                    auto_flag = stored_auto;
                    apply_level(stored_level);
                end
                CMD_DIM: begin
                    auto_flag = 0;
                    apply_level(int'(ev.req));
                end
                CMD_STEP: begin
                    auto_flag   = 0;
                    stored_auto = 0;
                    apply_level(level + d);
                    stored_level = level;
                end
                CMD_SET_AUTO: begin
                    auto_flag   = int'(ev.en);
                    stored_auto = int'(ev.en);
                    if (!ev.en) apply_level(stored_level);
                end
                CMD_ACTIVITY: begin
                    idle_count = 0;
                    if (asleep != 0) begin
                        asleep = 0;
                        apply_level(level);
                    end
                end
                CMD_TICK: begin
                    if (idle_count < IDLE_SAT) idle_count++;
                    if (idle_limit != 0 && asleep == 0 && idle_count > idle_limit) begin
                        asleep = 1;
                        drive  = 0;
                    end
                end
                CMD_LIGHT: begin
                    if (auto_flag != 0 && asleep == 0) begin
                        v = (ev.light > 100) ? 100 : int'(ev.light);
                        target = 1 + (v * (MAX_LEVEL - 1)) / 100;
                        if (target > level) apply_level(level + 1);
                        else if (target < level) apply_level(level - 1);
                    end
                end
                default: begin
                end
            endcase
            st.duty     = drive[6:0];
            st.level    = level[6:0];
            st.auto_on  = auto_flag[0];
            st.sleeping = asleep[0];
            expected_status.push_back(st);
        endfunction

        function void check_status(logic [15:0] data);
            bl_status_t exp_st;
            if (expected_status.size() == 0) begin
                $error("status item 0x%04h arrived with nothing expected", data);
                errors++;
                return;
            end
            exp_st = expected_status.pop_front();
            if (data[6:0] !== exp_st.duty) begin
                $error("duty_percent: expected %0d, actual %0d", exp_st.duty, data[6:0]);
                errors++;
            end
            if (data[13:7] !== exp_st.level) begin
                $error("current_level: expected %0d, actual %0d", exp_st.level, data[13:7]);
                errors++;
            end
            if (data[14] !== exp_st.auto_on) begin
                $error("auto_active: expected %0d, actual %0d", exp_st.auto_on, data[14]);
                errors++;
            end
            if (data[15] !== exp_st.sleeping) begin
                $error("sleeping: expected %0d, actual %0d", exp_st.sleeping, data[15]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [26:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // level_request, level_delta, auto_enable, light_reading
    logic [2:0]  s_axis_tuser;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // duty_percent, current_level, auto_active, sleeping

    backlight_predictor board;
    int stall_mode;
    int results_seen;
    int cycle_count;

    backlight_level_controller_core #(
        .MAX_LEVEL(MAX_LEVEL)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mode 0 runs without gaps, mode 1 draws every gap, mode 2 idles now and then.
    function automatic int draw_gap();
        case (stall_mode)
            0: return 0;
            1: return $urandom_range(0, 14);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        endcase
    endfunction

    function automatic bl_event_t make_event(logic [2:0] cmd, logic [7:0] req,
                                             logic [7:0] delta, logic en, logic [15:0] light);
        bl_event_t ev;
        ev.cmd   = cmd;
        ev.req   = req;
        ev.delta = delta;
        ev.en    = en;
        ev.light = light;
        return ev;
    endfunction

    // Ticks and light samples dominate so that sleep and the auto glide are reached often.
    function automatic bl_event_t random_event();
        bl_event_t ev;
        int pick;
        pick     = $urandom_range(0, 99);
        ev.req   = 8'($urandom_range(0, 255));
        ev.delta = 8'($urandom_range(0, 255));
        ev.en    = 1'($urandom_range(0, 1));
        ev.light = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 120)) :
                                                16'($urandom_range(0, 65535));
        if (pick < 30) ev.cmd = CMD_TICK;
        else if (pick < 55) ev.cmd = CMD_LIGHT;
        else if (pick < 65) ev.cmd = CMD_ACTIVITY;
        else if (pick < 75) ev.cmd = CMD_STEP;
        else if (pick < 83) ev.cmd = CMD_DIM;
        else if (pick < 93) ev.cmd = CMD_SET_AUTO;
        else if (pick < 99) ev.cmd = CMD_RESUME;
        else ev.cmd = CMD_UNUSED;
        return ev;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_event(bl_event_t ev);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev.cmd;
        s_axis_tdata  <= {7'd0, ev.light, ev.en, ev.delta, ev.req};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_event(ev);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_idle_limit(int v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[26:0];
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_idle_limit(v);
    endtask

    initial begin
        int phase_limit [NUM_PHASES];
        int per_phase;
        board         = new();
        stall_mode    = 2;
        results_seen  = 0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset idle limit: level extremes, clamping, auto mapping.
        send_event(make_event(CMD_DIM, 8'd0, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_DIM, 8'd255, 8'd0, 1'b1, 16'hFFFF));
        send_event(make_event(CMD_DIM, 8'd101, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_DIM, 8'd1, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_STEP, 8'd0, 8'h7F, 1'b0, 16'd0));
        send_event(make_event(CMD_STEP, 8'd0, 8'h80, 1'b0, 16'd0));
        send_event(make_event(CMD_STEP, 8'd0, 8'h00, 1'b0, 16'd0));
        send_event(make_event(CMD_SET_AUTO, 8'd0, 8'd0, 1'b1, 16'd0));
        send_event(make_event(CMD_LIGHT, 8'd0, 8'd0, 1'b0, 16'hFFFF));
        send_event(make_event(CMD_LIGHT, 8'd0, 8'd0, 1'b0, 16'd100));
        send_event(make_event(CMD_LIGHT, 8'd0, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_LIGHT, 8'd0, 8'd0, 1'b0, 16'd50));
        send_event(make_event(CMD_DIM, 8'd200, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_RESUME, 8'd0, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_SET_AUTO, 8'd0, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_ACTIVITY, 8'd0, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_TICK, 8'd0, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, 16'hFFFF));

        // Sleep entry, level changes while asleep, and wake-up by activity.
        write_idle_limit(2);
        send_event(make_event(CMD_SET_AUTO, 8'd0, 8'd0, 1'b1, 16'd0));
        repeat (3) send_event(make_event(CMD_TICK, 8'd0, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_LIGHT, 8'd0, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_DIM, 8'd40, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_ACTIVITY, 8'd0, 8'd0, 1'b0, 16'd0));
        send_event(make_event(CMD_TICK, 8'd0, 8'd0, 1'b0, 16'd0));

        phase_limit[0] = 0;
        phase_limit[1] = 1;
        phase_limit[2] = 86400000;
        phase_limit[3] = $urandom_range(3, 40);
        phase_limit[4] = 2;
        phase_limit[5] = $urandom_range(5, 60);
        phase_limit[6] = 30000;
        per_phase = RANDOM_ITEMS / NUM_PHASES;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_idle_limit(phase_limit[p]);
            stall_mode = p % 3;
            for (int i = 0; i < per_phase; i++) send_event(random_event());
        end

        drain_results();
        repeat (20) @(negedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Result side; one long hold-off lets the core back up and stall its input.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = (results_seen == PRESSURE_AT) ? PRESSURE_HOLD : draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            board.check_status(m_axis_tdata);
            results_seen++;
            @(negedge aclk);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/blc_pkg.sv
src/blc_update.sv
src/backlight_level_controller_core.sv
tb/backlight_level_controller_core_tb.sv
